### src/ilt_pkg.sv
`default_nettype none

package ilt_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_WRITE  = 3'd3,
		REQ_READ   = 3'd4
	} req_type_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int POS_W   = 6;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic ins;     // open a slot at position, load data there
		logic rem;     // close the slot at position
		logic wr_pos;  // overwrite the entry at position
		logic wr_app;  // write the entry at the current count
	} cmd_t;

	// decoder result for one request
	typedef struct packed {
		cmd_t    cmd;
		logic    rd_en;
		status_t status;
	} dec_t;

endpackage

`default_nettype wire

### src/ilt_req_if.sv
`default_nettype none

interface ilt_req_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      req_type;
	logic [ilt_pkg::POS_W-1:0]       position;
	logic signed [ilt_pkg::DATA_W-1:0] data_in;

	modport source (output valid, output req_type, output position, output data_in,
		input ready);
	modport sink (input valid, input req_type, input position, input data_in,
		output ready);
endinterface

`default_nettype wire

### src/ilt_rsp_if.sv
`default_nettype none

interface ilt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ilt_pkg::DATA_W-1:0] read_data;
	logic [ilt_pkg::COUNT_W-1:0]       entry_count;
	logic                              is_empty;
	logic [1:0]                        status;

	modport source (output valid, output read_data, output entry_count, output is_empty,
		output status, input ready);
	modport sink (input valid, input read_data, input entry_count, input is_empty,
		input status, output ready);
endinterface

`default_nettype wire

### src/ilt_ctrl.sv
`default_nettype none

module ilt_ctrl #(
	parameter int CAPACITY = 64,
	parameter int CNT_W    = 7
) (
	input  wire logic [2:0]                 req_type,
	input  wire logic [ilt_pkg::POS_W-1:0]  position,
	input  wire logic [CNT_W-1:0]           count,
	output ilt_pkg::dec_t                   dec,
	output logic      [CNT_W-1:0]           count_next
);

	localparam int CMP_W = (CNT_W > ilt_pkg::POS_W) ? CNT_W : ilt_pkg::POS_W;

	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic             in_range;
	logic             full;

	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(count);
	assign in_range = pos_c < cnt_c;
	assign full     = count >= CNT_W'(CAPACITY);

	always_comb begin
		dec        = '0;
		dec.status = ilt_pkg::ST_OK;
		count_next = count;
		case (req_type)
			ilt_pkg::REQ_APPEND: begin
				if (full) begin
					dec.status = ilt_pkg::ST_FULL;
				end else begin
					dec.cmd.wr_app = 1'b1;
					count_next     = count + CNT_W'(1);
				end
			end
			ilt_pkg::REQ_INSERT: begin
				if (!in_range) begin
					dec.status = ilt_pkg::ST_RANGE;
				end else if (full) begin
					dec.status = ilt_pkg::ST_FULL;
				end else begin
					dec.cmd.ins = 1'b1;
					count_next  = count + CNT_W'(1);
				end
			end
			ilt_pkg::REQ_REMOVE: begin
				if (!in_range) begin
					dec.status = ilt_pkg::ST_RANGE;
				end else begin
					dec.cmd.rem = 1'b1;
					count_next  = count - CNT_W'(1);
				end
			end
			ilt_pkg::REQ_WRITE: begin
				if (!in_range) begin
					dec.status = ilt_pkg::ST_RANGE;
				end else begin
					dec.cmd.wr_pos = 1'b1;
				end
			end
			ilt_pkg::REQ_READ: begin
				if (!in_range) begin
					dec.status = ilt_pkg::ST_RANGE;
				end else begin
					dec.rd_en = 1'b1;
				end
			end
			default: begin
				// unknown code: nothing changes
			end
		endcase
	end

endmodule

`default_nettype wire

### src/ilt_cell.sv
`default_nettype none

module ilt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  wire logic                              clk,
	input  wire ilt_pkg::cmd_t                     cmd,
	input  wire logic [ilt_pkg::POS_W-1:0]         position,
	input  wire logic [CNT_W-1:0]                  count,
	input  wire logic [ilt_pkg::DATA_W-1:0]        data_in,
	input  wire logic [ilt_pkg::DATA_W-1:0]        left_data,
	input  wire logic [ilt_pkg::DATA_W-1:0]        right_data,
	output logic      [ilt_pkg::DATA_W-1:0]        data,
	output logic      [ilt_pkg::DATA_W-1:0]        rd_data
);

	localparam int CMP_W = (CNT_W > ilt_pkg::POS_W) ? CNT_W : ilt_pkg::POS_W;

	logic [ilt_pkg::DATA_W-1:0] data_q;
	logic [CMP_W-1:0]           idx_c;
	logic [CMP_W-1:0]           pos_c;
	logic [CMP_W-1:0]           cnt_c;
	logic                       at_pos;
	logic                       above_pos;

	assign idx_c     = CMP_W'(IDX);
	assign pos_c     = CMP_W'(position);
	assign cnt_c     = CMP_W'(count);
	assign at_pos    = idx_c == pos_c;
	assign above_pos = idx_c > pos_c;

	always_ff @(posedge clk) begin
		if (cmd.ins && above_pos) begin
			data_q <= left_data;
		end else if (cmd.rem && (above_pos || at_pos)) begin
			data_q <= right_data;
		end else if ((cmd.ins || cmd.wr_pos) && at_pos) begin
			data_q <= data_in;
		end else if (cmd.wr_app && (idx_c == cnt_c)) begin
			data_q <= data_in;
		end
	end

	assign data    = data_q;
	// only the addressed cell drives its value toward the read OR
	assign rd_data = at_pos ? data_q : '0;

endmodule

`default_nettype wire

### src/indexed_list_table_core.sv
`default_nettype none

// indexed_list_table_core: ordered list of signed 32-bit entries, up to CAPACITY deep
//
// req (sink): one transaction per request; req_type selects append, insert,
//   remove, overwrite or read, position names the entry, data_in is the value
// rsp (source): one transaction per request with read_data, entry_count after
//   the request, is_empty and status (ok, index out of range, list full)
//
// storage is a row of cells, one per entry; insert and remove shift the cells from
// position upward toward their neighbor on the clock edge that takes the request, and
// the response is registered and shows up in the cycle after the request transaction
// throughput: one request per cycle while the receiver keeps taking responses
//
// the response sits in an output register; a new request is taken while that
// register is empty or being drained, so a stalled receiver holds off req.ready
// and the held response stays put until rsp.ready
//
// reset clears the entry count and the output valid; entry contents are not
// cleared, since only entries below the count are ever read

module indexed_list_table_core #(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ilt_req_if.sink   req,
	ilt_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DW    = ilt_pkg::DATA_W;

	logic             accept;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	ilt_pkg::dec_t    dec;
	ilt_pkg::cmd_t    cmd_eff;

	// cell row wiring
	logic [DW-1:0] cell_data [CAPACITY];
	logic [DW-1:0] cell_rd   [CAPACITY];
	logic [DW-1:0] rd_sel;

	// response register
	logic [DW-1:0]                 read_data_q;
	logic [ilt_pkg::COUNT_W-1:0]   entry_count_q;
	logic                          is_empty_q;
	logic [1:0]                    status_q;

	// take a request whenever the response slot is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	ilt_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.req_type   (req.req_type),
		.position   (req.position),
		.count      (count_q),
		.dec        (dec),
		.count_next (count_next)
	);

	// the cells only move on an accepted request
	assign cmd_eff = accept ? dec.cmd : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;

		// end cells see their own value where no neighbor exists
		if (i == 0) begin : g_first
			assign left_d = cell_data[i];
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		ilt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd_eff),
			.position   (req.position),
			.count      (count_q),
			.data_in    (req.data_in),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// at most one cell drives a nonzero read value
	always_comb begin
		rd_sel = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_sel = rd_sel | cell_rd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded with each request transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q   <= dec.rd_en ? rd_sel : '0;
			entry_count_q <= ilt_pkg::COUNT_W'(count_next);
			is_empty_q    <= count_next == '0;
			status_q      <= dec.status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_data   = read_data_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty    = is_empty_q;
	assign rsp.status      = status_q;

endmodule

`default_nettype wire
